/* src/ntp_pkg.sv */
// ntp_pkg: types and constants shared by the target pursuit controller
// no dependencies
`default_nettype none
package ntp_pkg;
  localparam logic [2:0] MODE_POSE   = 3'd0;
  localparam logic [2:0] MODE_ENTRY  = 3'd1;
  localparam logic [2:0] MODE_RESEL  = 3'd2;
  localparam logic [2:0] MODE_TICK   = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] REG_NEAREST = 2'd0;
  localparam logic [1:0] REG_LIN     = 2'd1;
  localparam logic [1:0] REG_ANG     = 2'd2;
  localparam logic [1:0] REG_CATCH   = 2'd3;

  localparam int ATAN_LEN = 24;
  localparam logic signed [15:0] PI_Q12 = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_Q12 = 16'sd25736;
  localparam logic signed [24:0] HALF_PI_Q16 = 25'sd102944;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         id;
  } slot_t;

  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 17'd51472;
      5'd1: atan_q16 = 17'd30386;
      5'd2: atan_q16 = 17'd16055;
      5'd3: atan_q16 = 17'd8150;
      5'd4: atan_q16 = 17'd4091;
      5'd5: atan_q16 = 17'd2047;
      5'd6: atan_q16 = 17'd1024;
      5'd7: atan_q16 = 17'd512;
      5'd8: atan_q16 = 17'd256;
      5'd9: atan_q16 = 17'd128;
      5'd10: atan_q16 = 17'd64;
      5'd11: atan_q16 = 17'd32;
      5'd12: atan_q16 = 17'd16;
      5'd13: atan_q16 = 17'd8;
      5'd14: atan_q16 = 17'd4;
      5'd15: atan_q16 = 17'd2;
      5'd16: atan_q16 = 17'd1;
      default: atan_q16 = 17'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* src/ntp_ram.sv */
// ntp_ram: generic simple dual port ram (one write port, one read port), registered read
// no dependencies
`default_nettype none
module ntp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/ntp_cordic.sv */
// ntp_cordic: iterative vectoring cordic for atan2, one micro-rotation a cycle
// depends on ntp_pkg
`default_nettype none
module ntp_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [16:0] dx,
  input  wire logic signed [16:0] dy,
  output logic                    done,
  output logic signed [15:0]      angle
);
  localparam int CW = $clog2(STEPS + 1);
  logic signed [35:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [24:0] z_r, z_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt, zero_r, zero_nxt;
  logic signed [35:0] xs, ys, x0, y0;
  logic signed [24:0] zr;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign x0 = 36'(dx) <<< 16;
  assign y0 = 36'(dy) <<< 16;
  assign zr = (z_r + 25'sd8) >>> 4;
  assign done = done_r;
  assign angle = zero_r ? 16'sd0 : 16'(zr);

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = 1'b0; zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1; i_nxt = '0;
      zero_nxt = (dx == 17'sd0) && (dy == 17'sd0);
      if (dx < 0) begin
        if (dy >= 0) begin
          x_nxt = y0; y_nxt = -x0; z_nxt = ntp_pkg::HALF_PI_Q16;
        end else begin
          x_nxt = -y0; y_nxt = x0; z_nxt = -ntp_pkg::HALF_PI_Q16;
        end
      end else begin
        x_nxt = x0; y_nxt = y0; z_nxt = '0;
      end
    end else if (busy_r) begin
      if (32'(i_r) == STEPS) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys; y_nxt = y_r - xs;
          z_nxt = z_r + 25'(ntp_pkg::atan_q16(5'(i_r)));
        end else begin
          x_nxt = x_r - ys; y_nxt = y_r + xs;
          z_nxt = z_r - 25'(ntp_pkg::atan_q16(5'(i_r)));
        end
        i_nxt = i_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; zero_r <= zero_nxt;
  end
endmodule
`default_nettype wire

/* src/ntp_isqrt.sv */
// ntp_isqrt: bit-serial integer square root of a 35 bit value, one result bit a cycle
// no dependencies
`default_nettype none
module ntp_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [34:0] val,
  output logic             done,
  output logic [17:0]      root
);
  logic [35:0] v_r, v_nxt, r_r, r_nxt, b_r, b_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  assign done = done_r;
  assign root = r_r[17:0];
  always_comb begin
    v_nxt = v_r; r_nxt = r_r; b_nxt = b_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      v_nxt = {1'b0, val}; r_nxt = '0; b_nxt = 36'd1 << 34; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= r_r + b_r) begin
        v_nxt = v_r - (r_r + b_r); r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r == 36'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    v_r <= v_nxt; r_r <= r_nxt; b_r <= b_nxt;
  end
endmodule
`default_nettype wire

/* src/nearest_target_pursuit_controller_unit.sv */
// nearest_target_pursuit_controller_unit: top level, sequencer around the target list ram
// depends on ntp_pkg, ntp_ram, ntp_cordic, ntp_isqrt
// Usage: input words arrive on in_valid/in_stall, one at a time; results leave on
// out_valid/out_stall from an output register. Configuration writes go through
// cfg_valid/cfg_ready with cfg_index and cfg_data while the block is idle.
// Pose, clear, reselect on an empty list and non-last target words are taken
// without a stall, so they can follow back to back. A selection sweeps the list
// ram, one entry a cycle: input is stalled until the sweep ends.
// A control tick with a target first forms the squared distance (S_DSQ, S_D2). A
// catch then puts its word out through S_CHK and S_OUT. Otherwise the square-root
// unit runs, then the CORDIC, then one multiply and one saturation step, and input
// stays stalled until the word is out. Most of this time goes to the sequential
// square root and CORDIC. Ticks without a target give no word.
// Reset clears the pose, list count and chosen target and loads the register
// defaults; the list ram is not cleared. While a result waits under out_stall the
// input is stalled as well.
`default_nettype none
module nearest_target_pursuit_controller_unit #(
  parameter int MAX_TARGETS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [14:0] in_heading,
  input  wire logic signed [15:0] in_target_x,
  input  wire logic signed [15:0] in_target_y,
  input  wire logic [7:0]  in_target_id,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic        in_last_entry,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_linear_cmd,
  output logic signed [15:0] out_angular_cmd,
  output logic             out_caught,
  output logic [7:0]       out_caught_id
);
  localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNTW = $clog2(MAX_TARGETS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEL  = 4'd1;
  localparam logic [3:0] S_SELW = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SQW  = 4'd4;
  localparam logic [3:0] S_COR  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DSQ  = 4'd9;
  localparam logic [3:0] S_D2   = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic nearest_r;
  logic [15:0] lin_gain_r, ang_gain_r, catch_r;
  logic signed [15:0] rx_r, ry_r;
  logic signed [14:0] rh_r;
  logic [CNTW-1:0] cnt_r;
  logic signed [15:0] cx_r, cy_r;
  logic [7:0] cid_r;
  logic cvalid_r;

  // selection sweep
  logic [CNTW-1:0] si_r, sn_r;
  logic [34:0] bd_r;
  logic best_set_r;
  logic [CNTW-1:0] rd_idx_r;

  // tick datapath registers
  logic signed [16:0] dx_r, dy_r;
  logic [33:0] dx2_r, dy2_r;
  logic [34:0] d2_r;
  logic [31:0] c2_r;
  logic [17:0] dist_r;
  logic [33:0] lin_r;
  logic signed [16:0] err_r;
  logic signed [33:0] ang_r;

  logic [15:0] o_lin_r;
  logic signed [15:0] o_ang_r;
  logic o_caught_r, out_valid_r;
  logic [7:0] o_id_r;

  logic accept, ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  ntp_pkg::slot_t ram_wdata, ram_rdata;

  logic sq_start, sq_done, cor_start, cor_done;
  logic [17:0] sq_root;
  logic signed [15:0] cor_angle;

  assign in_stall = (st_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept = in_valid && !in_stall;
  assign cfg_ready = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_linear_cmd = o_lin_r;
  assign out_angular_cmd = o_ang_r;
  assign out_caught = o_caught_r;
  assign out_caught_id = o_id_r;

  assign ram_we = accept && (in_mode == ntp_pkg::MODE_ENTRY) &&
                  (32'(in_entry_index) < MAX_TARGETS);
  assign ram_waddr = AW'(in_entry_index);
  assign ram_wdata = '{x: in_target_x, y: in_target_y, id: in_target_id};
  assign ram_raddr = si_r[AW-1:0];

  ntp_ram #(.WIDTH($bits(ntp_pkg::slot_t)), .DEPTH(1 << AW)) u_list (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  ntp_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(d2_r),
    .done(sq_done), .root(sq_root)
  );

  ntp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .dx(dx_r), .dy(dy_r),
    .done(cor_done), .angle(cor_angle)
  );

  logic signed [16:0] sdx, sdy;
  logic [34:0] sd2;
  assign sdx = 17'(ram_rdata.x) - 17'(rx_r);
  assign sdy = 17'(ram_rdata.y) - 17'(ry_r);
  assign sd2 = 35'(34'(sdx) * 34'(sdx)) + 35'(34'(sdy) * 34'(sdy));

  assign sq_start = (st_r == S_SQ);
  assign cor_start = (st_r == S_SQW) && sq_done;

  logic go_sel;
  always_comb begin
    go_sel = 1'b0;
    if (accept) begin
      if (in_mode == ntp_pkg::MODE_RESEL) go_sel = (cnt_r != '0);
      if (ram_we && in_last_entry) go_sel = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (go_sel) st_nxt = S_SEL;
        else if (accept && in_mode == ntp_pkg::MODE_TICK && cvalid_r) st_nxt = S_DSQ;
      end
      S_SEL:  st_nxt = S_SELW;
      S_SELW: if (si_r >= sn_r) st_nxt = S_IDLE;
      S_DSQ:  st_nxt = S_D2;
      S_D2:   st_nxt = S_CHK;
      S_CHK:  st_nxt = (d2_r <= 35'(c2_r)) ? S_OUT : S_SQ;
      S_SQ:   st_nxt = S_SQW;
      S_SQW:  if (sq_done) st_nxt = S_COR;
      S_COR:  if (cor_done) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic signed [16:0] err0;
  always_comb begin
    err0 = 17'(cor_angle) - 17'(rh_r);
    if (err0 < -17'(ntp_pkg::PI_Q12)) err0 = err0 + 17'(ntp_pkg::TWO_PI_Q12);
    else if (err0 > 17'(ntp_pkg::PI_Q12)) err0 = err0 - 17'(ntp_pkg::TWO_PI_Q12);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      nearest_r <= 1'b1; lin_gain_r <= 16'd512; ang_gain_r <= 16'd3840;
      catch_r <= 16'd128;
      rx_r <= '0; ry_r <= '0; rh_r <= '0; cnt_r <= '0;
      cx_r <= '0; cy_r <= '0; cid_r <= '0; cvalid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && !out_stall && st_r != S_OUT) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ntp_pkg::REG_NEAREST: nearest_r <= cfg_data[0];
          ntp_pkg::REG_LIN:     lin_gain_r <= cfg_data;
          ntp_pkg::REG_ANG:     ang_gain_r <= cfg_data;
          ntp_pkg::REG_CATCH:   catch_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        case (in_mode)
          ntp_pkg::MODE_POSE: begin
            rx_r <= in_pos_x; ry_r <= in_pos_y; rh_r <= in_heading;
          end
          ntp_pkg::MODE_CLEAR: cnt_r <= '0;
          default: ;
        endcase
        if (ram_we && in_last_entry) cnt_r <= CNTW'(in_entry_index) + 1'b1;
      end
      // select: chosen target follows the best entry as the sweep runs (the first entry when nearest mode is off)
      if (st_r == S_SELW && si_r >= sn_r) begin
        cvalid_r <= 1'b1;
      end
      if (st_r == S_SELW && rd_idx_r < sn_r) begin
        if (!best_set_r || (nearest_r && sd2 < bd_r)) begin
          cx_r <= ram_rdata.x; cy_r <= ram_rdata.y; cid_r <= ram_rdata.id;
        end
      end
      if (st_r == S_OUT) begin
        out_valid_r <= 1'b1;
        if (o_caught_r) cvalid_r <= 1'b0;
      end
    end
  end

  // sweep and datapath, no reset needed
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && go_sel) begin
      si_r <= '0;
      sn_r <= (ram_we && in_last_entry) ? CNTW'(in_entry_index) + 1'b1 : cnt_r;
      best_set_r <= 1'b0;
    end
    if (st_r == S_SEL) begin
      rd_idx_r <= si_r;
      si_r <= si_r + 1'b1;
    end
    if (st_r == S_SELW) begin
      if (rd_idx_r < sn_r) begin
        if (!best_set_r || (nearest_r && sd2 < bd_r)) begin
          bd_r <= sd2;
        end
        best_set_r <= 1'b1;
      end
      rd_idx_r <= si_r;
      if (si_r < sn_r) si_r <= si_r + 1'b1;
    end
    if (accept && in_mode == ntp_pkg::MODE_TICK) begin
      dx_r <= 17'(cx_r) - 17'(rx_r);
      dy_r <= 17'(cy_r) - 17'(ry_r);
      c2_r <= catch_r * catch_r;
    end
    dx2_r <= 34'(dx_r) * 34'(dx_r);
    dy2_r <= 34'(dy_r) * 34'(dy_r);
    if (st_r == S_D2) begin
      d2_r <= 35'(dx2_r) + 35'(dy2_r);
    end
    if (sq_done) dist_r <= sq_root;
    if (cor_done) begin
      err_r <= err0;
      lin_r <= 34'(dist_r) * 34'(lin_gain_r);
    end
    if (st_r == S_MUL) ang_r <= 34'(err_r) * $signed({18'd0, ang_gain_r});
    if (st_r == S_CHK) begin
      o_caught_r <= (d2_r <= 35'(c2_r));
      if (d2_r <= 35'(c2_r)) begin
        o_id_r <= cid_r; o_lin_r <= '0; o_ang_r <= '0;
      end else begin
        o_id_r <= '0;
      end
    end
    if (st_r == S_OUT && !o_caught_r) begin
      o_lin_r <= (lin_r[33:8] > 26'd65535) ? 16'hFFFF : lin_r[23:8];
      if ((ang_r >>> 12) > 34'sd32767) o_ang_r <= 16'sd32767;
      else if ((ang_r >>> 12) < -34'sd32768) o_ang_r <= -16'sd32768;
      else o_ang_r <= 16'(ang_r >>> 12);
    end
  end
endmodule
`default_nettype wire

/* sim/nearest_target_pursuit_controller_unit_test.sv */
// nearest_target_pursuit_controller_unit_test: self-checking bench for the pursuit controller
// depends on ntp_pkg and nearest_target_pursuit_controller_unit; carries its own command predictor
`default_nettype none
module nearest_target_pursuit_controller_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_STEPS = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [15:0]        lin;
    logic signed [15:0] ang;
    logic               caught;
    logic [7:0]         id;
  } cmd_t;

  typedef struct {
    logic [2:0]         mode;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [14:0] hd;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic [7:0]         tid;
    logic [3:0]         idx;
    logic               last;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_mode = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_target_x = '0, in_target_y = '0;
  logic signed [14:0] in_heading = '0;
  logic [7:0] in_target_id = '0;
  logic [3:0] in_entry_index = '0;
  logic in_last_entry = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_linear_cmd;
  logic signed [15:0] out_angular_cmd;
  logic out_caught;
  logic [7:0] out_caught_id;

  nearest_target_pursuit_controller_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic        near_mode;
  longint      lin_gain, ang_gain, catch_dist;
  longint      rob_x, rob_y, rob_hd;
  longint      slot_x [NUM_SLOTS];
  longint      slot_y [NUM_SLOTS];
  logic [7:0]  slot_id [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_written;
  int          count;
  longint      goal_x, goal_y;
  logic [7:0]  goal_id;
  logic        goal_valid;

  cmd_t pending_cmds [$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 1'b0;

  const longint atan_tab [NUM_STEPS] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                          256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint range_sq(longint tx, longint ty);
    longint dx, dy;
    dx = tx - rob_x;
    dy = ty - rob_y;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // cordic vectoring atan2, q4.12
  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ntp_pkg::HALF_PI_Q16;
      end else begin
        t = x; x = -y; y = t; z = -ntp_pkg::HALF_PI_Q16;
      end
    end
    for (int i = 0; i < NUM_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic void pick_goal();
    int best;
    longint bd, d;
    best = 0;
    if (count == 0) return;
    if (near_mode) begin
      bd = range_sq(slot_x[0], slot_y[0]);
      for (int i = 1; i < count; i++) begin
        d = range_sq(slot_x[i], slot_y[i]);
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
    end
    goal_x = slot_x[best];
    goal_y = slot_y[best];
    goal_id = slot_id[best];
    goal_valid = 1'b1;
  endfunction

  function automatic void predict_word(word_t w);
    cmd_t c;
    longint dx, dy, d2, lin, err, ang;
    case (w.mode)
      ntp_pkg::MODE_POSE: begin
        rob_x = w.px;
        rob_y = w.py;
        rob_hd = w.hd;
      end
      ntp_pkg::MODE_ENTRY: begin
        slot_x[w.idx] = w.tx;
        slot_y[w.idx] = w.ty;
        slot_id[w.idx] = w.tid;
        slot_written[w.idx] = 1'b1;
        if (w.last) begin
          count = int'(w.idx) + 1;
          pick_goal();
        end
      end
      ntp_pkg::MODE_RESEL: pick_goal();
      ntp_pkg::MODE_CLEAR: count = 0;
      ntp_pkg::MODE_TICK: begin
        if (goal_valid) begin
          dx = goal_x - rob_x;
          dy = goal_y - rob_y;
          d2 = dx * dx + dy * dy;
          if (d2 <= catch_dist * catch_dist) begin
            c = '{lin: '0, ang: '0, caught: 1'b1, id: goal_id};
            goal_valid = 1'b0;
          end else begin
            lin = (int_sqrt(d2) * lin_gain) >>> 8;
            if (lin > 65535) lin = 65535;
            err = bearing_q12(dx, dy) - rob_hd;
            if (err < -ntp_pkg::PI_Q12) err += ntp_pkg::TWO_PI_Q12;
            else if (err > ntp_pkg::PI_Q12) err -= ntp_pkg::TWO_PI_Q12;
            ang = (err * ang_gain) >>> 12;
            if (ang > 32767) ang = 32767;
            if (ang < -32768) ang = -32768;
            c = '{lin: lin[15:0], ang: ang[15:0], caught: 1'b0, id: '0};
          end
          pending_cmds = {pending_cmds, c};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    cmd_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        e = pending_cmds.pop_front();
        if (out_linear_cmd !== e.lin) report("linear_cmd", out_linear_cmd, e.lin);
        if (out_angular_cmd !== e.ang) report("angular_cmd", out_angular_cmd, e.ang);
        if (out_caught !== e.caught) report("caught", out_caught, e.caught);
        if (out_caught_id !== e.id) report("caught_id", out_caught_id, e.id);
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver backpressure
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = idle_len();
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(word_t w);
    int gap;
    @(negedge clk);
    in_mode = w.mode;
    in_pos_x = w.px;
    in_pos_y = w.py;
    in_heading = w.hd;
    in_target_x = w.tx;
    in_target_y = w.ty;
    in_target_id = w.tid;
    in_entry_index = w.idx;
    in_last_entry = w.last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_word(w);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ntp_pkg::REG_NEAREST: near_mode = data[0];
      ntp_pkg::REG_LIN:     lin_gain = data;
      ntp_pkg::REG_ANG:     ang_gain = data;
      ntp_pkg::REG_CATCH:   catch_dist = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic word_t blank_word(logic [2:0] m);
    word_t w;
    w = '{mode: m, px: '0, py: '0, hd: '0, tx: '0, ty: '0, tid: '0, idx: '0, last: 1'b0};
    return w;
  endfunction

  function automatic word_t entry_word(int idx, longint x, longint y, int id, bit last);
    word_t w;
    w = blank_word(ntp_pkg::MODE_ENTRY);
    w.idx = 4'(idx);
    w.tx = 16'(x);
    w.ty = 16'(y);
    w.tid = 8'(id);
    w.last = last;
    return w;
  endfunction

  function automatic word_t pose_word(longint x, longint y, longint h);
    word_t w;
    w = blank_word(ntp_pkg::MODE_POSE);
    w.px = 16'(x);
    w.py = 16'(y);
    w.hd = 15'(h);
    return w;
  endfunction

  // a list end may only cover slots that hold a written entry
  function automatic bit slots_ready(logic [3:0] idx);
    for (int i = 0; i < int'(idx); i++) begin
      if (!slot_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic test_directed();
    word_t w;
    send_word(blank_word(ntp_pkg::MODE_TICK));         // no target yet
    send_word(blank_word(ntp_pkg::MODE_RESEL));        // empty list keeps nothing chosen
    send_word(blank_word(ntp_pkg::MODE_TICK));
    for (int i = 0; i < NUM_SLOTS; i++)
      send_word(entry_word(i, (i * 4099) - 32768, 32767 - i * 3001, 255 - i, i == NUM_SLOTS - 1));
    send_word(pose_word(-32768, 32767, 12868));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    send_word(pose_word(32767, -32768, -12868));
    send_word(blank_word(ntp_pkg::MODE_RESEL));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    send_word(pose_word(0, 0, 15'sh3fff));             // heading beyond pi
    send_word(blank_word(ntp_pkg::MODE_TICK));
    send_word(pose_word(0, 0, 15'sh4000));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    // park on the chosen target: caught, then dropped
    send_word(pose_word(goal_x, goal_y, 0));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    send_word(blank_word(ntp_pkg::MODE_CLEAR));
    send_word(blank_word(ntp_pkg::MODE_RESEL));        // cleared list keeps goal as is
    send_word(blank_word(ntp_pkg::MODE_TICK));
    for (int m = 5; m < 8; m++) begin
      w = blank_word(3'(m));
      w.px = 16'h7fff;
      w.idx = 4'hf;
      w.last = 1'b1;
      send_word(w);
    end
    send_word(entry_word(0, 256, 0, 8'haa, 1'b1));
    send_word(pose_word(0, 0, 0));
    send_word(blank_word(ntp_pkg::MODE_TICK));
    wait_drained();
  endtask

  function automatic longint rand_coord();
    if ($urandom_range(3) == 0) return $signed(16'($urandom));
    return $signed(16'($urandom_range(4096))) - 2048;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int r;
    r = $urandom_range(99);
    w = blank_word(ntp_pkg::MODE_TICK);
    w.px = 16'($urandom);
    w.py = 16'($urandom);
    w.hd = 15'($urandom);
    w.tx = 16'($urandom);
    w.ty = 16'($urandom);
    w.tid = 8'($urandom);
    w.idx = 4'($urandom);
    w.last = 1'($urandom);
    if (r < 18) begin
      w.mode = ntp_pkg::MODE_POSE;
      if ($urandom_range(2) == 0 && goal_valid) begin
        // sit on or near the goal to get catches
        w.px = 16'(goal_x + $signed(9'($urandom)) - 256);
        w.py = 16'(goal_y + $signed(9'($urandom)) - 256);
      end else begin
        w.px = 16'(rand_coord());
        w.py = 16'(rand_coord());
      end
      if ($urandom_range(4) != 0) w.hd = 15'($urandom_range(25736) - 12868);
    end else if (r < 45) begin
      w.mode = ntp_pkg::MODE_ENTRY;
      w.tx = 16'(rand_coord());
      w.ty = 16'(rand_coord());
      w.last = ($urandom_range(2) == 0) && slots_ready(w.idx);
    end else if (r < 53) w.mode = ntp_pkg::MODE_RESEL;
    else if (r < 56) w.mode = ntp_pkg::MODE_CLEAR;
    else if (r < 59) w.mode = 3'($urandom_range(7, 5));
    return w;
  endfunction

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_word(rand_word());
    wait_drained();
  endtask

  task automatic test_settings();
    quiet = 1'b1;
    write_reg(ntp_pkg::REG_NEAREST, 16'd0);
    write_reg(ntp_pkg::REG_LIN, 16'hffff);
    write_reg(ntp_pkg::REG_ANG, 16'hffff);
    write_reg(ntp_pkg::REG_CATCH, 16'd0);
    test_random(200);
    quiet = 1'b0;
    write_reg(ntp_pkg::REG_NEAREST, 16'hfffe);         // only bit 0 kept
    write_reg(ntp_pkg::REG_LIN, 16'd0);
    write_reg(ntp_pkg::REG_ANG, 16'd0);
    write_reg(ntp_pkg::REG_CATCH, 16'hffff);
    test_random(150);
    write_reg(ntp_pkg::REG_NEAREST, 16'd1);
    write_reg(ntp_pkg::REG_LIN, 16'd256);
    write_reg(ntp_pkg::REG_ANG, 16'd4096);
    write_reg(ntp_pkg::REG_CATCH, 16'd300);
    test_random(350);
    for (int p = 0; p < 3; p++) begin
      write_reg(ntp_pkg::REG_NEAREST, 16'($urandom));
      write_reg(ntp_pkg::REG_LIN, 16'($urandom));
      write_reg(ntp_pkg::REG_ANG, 16'($urandom));
      write_reg(ntp_pkg::REG_CATCH, 16'($urandom_range(1024)));
      test_random(250);
    end
  endtask

  initial begin
    near_mode = 1'b1;
    lin_gain = 512;
    ang_gain = 3840;
    catch_dist = 128;
    rob_x = 0; rob_y = 0; rob_hd = 0;
    slot_written = '0;
    count = 0;
    goal_x = 0; goal_y = 0; goal_id = '0; goal_valid = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(150);
    test_settings();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
